@@ rtl/assert_macros.svh @@
// Assertion helpers for the file that checks its own logic (sensor_guarded_axis_mover).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/sgam_pkg.sv @@
package sgam_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_AXIS_LENGTH = 3'd0;
    localparam logic [2:0] REG_BUFFER_ZONE = 3'd1;
    localparam logic [2:0] REG_CREEP_STEP  = 3'd2;
    localparam logic [2:0] REG_OVERSHOOT   = 3'd3;
    localparam logic [2:0] REG_MOVE_SPEED  = 3'd4;
    localparam logic [2:0] REG_END_SENSOR  = 3'd5;

    localparam logic [22:0] AXIS_LENGTH_RST = 23'd64000;
    localparam logic [22:0] BUFFER_ZONE_RST = 23'd1920;
    localparam logic [15:0] CREEP_STEP_RST  = 16'd192;
    localparam logic [15:0] OVERSHOOT_RST   = 16'd0;
    localparam logic [15:0] MOVE_SPEED_RST  = 16'd640;
    localparam logic        END_SENSOR_RST  = 1'b1;

    typedef struct packed {
        logic [22:0] axis_length;
        logic [22:0] buffer_zone;
        logic [15:0] creep_step;
        logic [15:0] overshoot;
        logic [15:0] move_speed;
        logic        end_sensor_present;
    } t_cfg;

    typedef struct packed {
        logic move_valid;
        logic finished;
        logic speed_error;
    } t_flags;

endpackage

@@ rtl/sensor_guarded_axis_mover.sv @@
// A beat accepted is held in the input register, then moved into the result register when
// it advances, and leaves on the master side. Throughput: one beat per cycle while
// m_axis_tready is high; the result register frees a slot each cycle it drains.
// The position and mode registers are updated once per beat, when it moves to the output.
// Reset is synchronous, active low: position -1 mm (uncalibrated), goal 0, mode idle,
// configuration registers back to their defaults, both beat registers empty.

`include "assert_macros.svh"

module sensor_guarded_axis_mover #(
    parameter int POSITION_BITS = 24,
    parameter int FRACTION_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port, one register per 32-bit word.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: target, home_triggered, end_triggered, zero fill.
    input  logic [((POSITION_BITS + 2 + 7) / 8) * 8 - 1:0]     s_axis_tdata,
    // Fields from bit 0: kind.
    input  logic                  s_axis_tuser,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: move_valid, move_delta, finished, speed_error,
    // position_now, zero fill.
    output logic [((2 * POSITION_BITS + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int P     = POSITION_BITS;
    localparam int IN_W  = ((P + 2 + 7) / 8) * 8;
    localparam int OUT_W = ((2 * P + 4 + 7) / 8) * 8;

    sgam_pkg::t_cfg   w_cfg;
    sgam_pkg::t_flags w_flags;
    logic [P:0]       w_delta;
    logic [P-1:0]     w_pos;

    // Input register: holds one beat while the core works on it.
    logic             r_in_valid;
    logic             r_in_kind;
    logic [P-1:0]     r_in_target;
    logic             r_in_home;
    logic             r_in_end;

    // Result register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic             w_adv;

    // The held beat moves on whenever the result register is empty or draining,
    // and a new beat can enter in the same cycle.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    sgam_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sgam_core #(
        .POSITION_BITS (POSITION_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_adv    (w_adv),
        .i_kind   (r_in_kind),
        .i_target (r_in_target),
        .i_home   (r_in_home),
        .i_end    (r_in_end),
        .o_flags  (w_flags),
        .o_delta  (w_delta),
        .o_pos    (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind   <= s_axis_tuser;
            r_in_target <= s_axis_tdata[P-1:0];
            r_in_home   <= s_axis_tdata[P];
            r_in_end    <= s_axis_tdata[P+1];
        end
        if (w_adv) begin
            r_out_data <= {{(OUT_W-2*P-4){1'b0}}, w_pos, w_flags.speed_error,
                           w_flags.finished, w_delta, w_flags.move_valid};
        end
    end

    // A stalled input side can only come from a full result register that is not drained.
    `ASSERT_IMP(a_stall_source, i_clk, i_rst_n, !s_axis_tready,
                r_in_valid && r_out_valid && !m_axis_tready)
    // No move means a zero delta.
    `ASSERT_IMP(a_idle_delta, i_clk, i_rst_n, r_out_valid && !r_out_data[0],
                r_out_data[P+1:1] == '0)
    // A refused command is finished and never issues a move.
    `ASSERT_IMP(a_refusal, i_clk, i_rst_n, r_out_valid && r_out_data[P+3],
                r_out_data[P+2] && !r_out_data[0])
    // A beat handed to the result register is shown there in the next cycle.
    `ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, w_adv, r_out_valid)

endmodule

@@ rtl/sgam_regs.sv @@
module sgam_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sgam_pkg::t_cfg     o_cfg
);

    sgam_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic           w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_length        <= sgam_pkg::AXIS_LENGTH_RST;
            r_cfg.buffer_zone        <= sgam_pkg::BUFFER_ZONE_RST;
            r_cfg.creep_step         <= sgam_pkg::CREEP_STEP_RST;
            r_cfg.overshoot          <= sgam_pkg::OVERSHOOT_RST;
            r_cfg.move_speed         <= sgam_pkg::MOVE_SPEED_RST;
            r_cfg.end_sensor_present <= sgam_pkg::END_SENSOR_RST;
        end else if (w_write) begin
            unique case (w_index)
                sgam_pkg::REG_AXIS_LENGTH: r_cfg.axis_length <= pwdata[22:0];
                sgam_pkg::REG_BUFFER_ZONE: r_cfg.buffer_zone <= pwdata[22:0];
                sgam_pkg::REG_CREEP_STEP:  r_cfg.creep_step  <= pwdata[15:0];
                sgam_pkg::REG_OVERSHOOT:   r_cfg.overshoot   <= pwdata[15:0];
                sgam_pkg::REG_MOVE_SPEED:  r_cfg.move_speed  <= pwdata[15:0];
                sgam_pkg::REG_END_SENSOR:  r_cfg.end_sensor_present <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            sgam_pkg::REG_AXIS_LENGTH: prdata = {9'd0, r_cfg.axis_length};
            sgam_pkg::REG_BUFFER_ZONE: prdata = {9'd0, r_cfg.buffer_zone};
            sgam_pkg::REG_CREEP_STEP:  prdata = {16'd0, r_cfg.creep_step};
            sgam_pkg::REG_OVERSHOOT:   prdata = {16'd0, r_cfg.overshoot};
            sgam_pkg::REG_MOVE_SPEED:  prdata = {16'd0, r_cfg.move_speed};
            sgam_pkg::REG_END_SENSOR:  prdata = {31'd0, r_cfg.end_sensor_present};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/sgam_core.sv @@
module sgam_core #(
    parameter int POSITION_BITS = 24,
    parameter int FRACTION_BITS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sgam_pkg::t_cfg           i_cfg,
    input  logic                     i_adv,
    input  logic                     i_kind,
    input  logic [POSITION_BITS-1:0] i_target,
    input  logic                     i_home,
    input  logic                     i_end,
    output sgam_pkg::t_flags         o_flags,
    output logic [POSITION_BITS:0]   o_delta,
    output logic [POSITION_BITS-1:0] o_pos
);

    localparam int P  = POSITION_BITS;
    // Working width covers the position range and the 23 bit configuration values.
    localparam int CW = ((P > 24) ? P : 24) + 2;
    localparam logic signed [CW-1:0] PMAX = {{(CW-P+1){1'b0}}, {(P-1){1'b1}}};
    localparam logic signed [CW-1:0] PMIN = {{(CW-P+1){1'b1}}, {(P-1){1'b0}}};
    localparam logic [P-1:0] ONE_MM = P'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HOME,
        MODE_END
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [P-1:0]   r_pos;
    logic [P-1:0]   r_goal;

    logic signed [CW-1:0] pos, goal, t, hb, eb, alen, creep, ovs, g_sel;
    logic signed [CW-1:0] np_h, np_e, np_o, hb_s, eb_s, n_pos, n_goal, delta;
    logic                 fin_h, fin_e, home, endt, valid, fin, err;

    function automatic logic signed [CW-1:0] f_sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > PMAX) begin
            r = PMAX;
        end else if (v < PMIN) begin
            r = PMIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Still short of the goal and of the axis length.
    function automatic logic f_endc(input logic signed [CW-1:0] p,
                                    input logic signed [CW-1:0] g,
                                    input logic signed [CW-1:0] l);
        return (p < g) && (p < l);
    endfunction

    always_comb begin
        pos   = {{(CW-P){r_pos[P-1]}}, r_pos};
        goal  = {{(CW-P){r_goal[P-1]}}, r_goal};
        t     = {{(CW-P){i_target[P-1]}}, i_target};
        hb    = {{(CW-23){1'b0}}, i_cfg.buffer_zone};
        alen  = {{(CW-23){1'b0}}, i_cfg.axis_length};
        eb    = alen - hb;
        creep = {{(CW-16){1'b0}}, i_cfg.creep_step};
        ovs   = {{(CW-16){1'b0}}, i_cfg.overshoot};
        home  = i_home;
        endt  = i_end && i_cfg.end_sensor_present;
        g_sel = i_kind ? goal : t;

        np_h  = f_sat(pos - creep);
        fin_h = (np_h <= g_sel) || (np_h == pos);
        np_e  = f_sat(pos + creep);
        fin_e = !f_endc(np_e, g_sel, alen) || (np_e == pos);
        np_o  = f_sat(pos + ovs);
        hb_s  = f_sat(hb);
        eb_s  = f_sat(eb);

        n_pos  = pos;
        n_goal = goal;
        n_mode = r_mode;
        valid  = 1'b0;
        delta  = '0;
        fin    = 1'b0;
        err    = 1'b0;

        if (!i_kind) begin
            n_mode = MODE_IDLE;
            if (i_cfg.move_speed == 16'd0) begin
                fin = 1'b1;
                err = 1'b1;
            end else begin
                n_goal = t;
                if ((t < pos) && (t < hb)) begin
                    if (home) begin
                        fin = 1'b1;
                    end else if (pos > hb) begin
                        n_pos = hb_s;
                        delta = hb_s - pos;
                        valid = 1'b1;
                        if (hb_s > t) begin
                            n_mode = MODE_HOME;
                        end else begin
                            fin = 1'b1;
                        end
                    end else begin
                        n_pos = np_h;
                        delta = np_h - pos;
                        valid = 1'b1;
                        fin   = fin_h;
                        if (!fin_h) begin
                            n_mode = MODE_HOME;
                        end
                    end
                end else if ((t > pos) && (t > eb)) begin
                    if (endt) begin
                        fin = 1'b1;
                    end else if (pos < eb) begin
                        n_pos = eb_s;
                        delta = eb_s - pos;
                        valid = 1'b1;
                        if (f_endc(eb_s, t, alen)) begin
                            n_mode = MODE_END;
                        end else begin
                            fin = 1'b1;
                        end
                    end else if (f_endc(pos, t, alen)) begin
                        n_pos = np_e;
                        delta = np_e - pos;
                        valid = 1'b1;
                        fin   = fin_e;
                        if (!fin_e) begin
                            n_mode = MODE_END;
                        end
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_pos = t;
                    delta = t - pos;
                    valid = 1'b1;
                    fin   = 1'b1;
                end
            end
        end else begin
            unique case (r_mode)
                MODE_HOME: begin
                    valid = 1'b1;
                    if (home) begin
                        // Home sensor seen: the axis is zeroed here.
                        n_pos = '0;
                        delta = -ovs;
                        fin   = 1'b1;
                    end else begin
                        n_pos = np_h;
                        delta = np_h - pos;
                        fin   = fin_h;
                    end
                    if (fin) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_END: begin
                    valid = 1'b1;
                    if (endt) begin
                        n_pos = np_o;
                        delta = np_o - pos;
                        fin   = 1'b1;
                    end else begin
                        n_pos = np_e;
                        delta = np_e - pos;
                        fin   = fin_e;
                    end
                    if (fin) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_flags.move_valid  = valid;
    assign o_flags.finished    = fin;
    assign o_flags.speed_error = err;
    assign o_delta = valid ? delta[P:0] : '0;
    assign o_pos   = n_pos[P-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= '0 - ONE_MM;
            r_goal <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_pos  <= n_pos[P-1:0];
            r_goal <= n_goal[P-1:0];
        end
    end

endmodule
